// ===== rtl/vrst_pkg.sv =====
// ----------------------------------------------------------------------------
// vrst_pkg
// Shared codes, the classified item type and the key record format check
// for the validation record session tracker.
// ----------------------------------------------------------------------------
package vrst_pkg;

    // Item kinds
    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_INIT = 2'd2;

    // Command classes
    localparam logic [2:0] CLS_OTHER      = 3'd0;
    localparam logic [2:0] CLS_REC_TRUE   = 3'd1;
    localparam logic [2:0] CLS_REC_FALSE  = 3'd2;
    localparam logic [2:0] CLS_REC_OTHER  = 3'd3;
    localparam logic [2:0] CLS_VALIDATION = 3'd4;
    localparam logic [2:0] CLS_VALOFF     = 3'd5;
    localparam logic [2:0] CLS_UNKNOWN    = 3'd6;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_OK     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN    = 3'd2;
    localparam logic [2:0] ST_INIT_INCMP = 3'd3;
    localparam logic [2:0] ST_QVAL_BAD   = 3'd4;
    localparam logic [2:0] ST_RECORD_BAD = 3'd5;
    localparam logic [2:0] ST_QUEUE_FULL = 3'd6;

    // Response kinds
    localparam logic [1:0] RK_NONE   = 2'd0;
    localparam logic [1:0] RK_DEVICE = 2'd1;
    localparam logic [1:0] RK_OTHER  = 2'd2;

    // Init choice codes
    localparam logic [1:0] CHOICE_UNKNOWN = 2'd0;
    localparam logic [1:0] CHOICE_VAL_OFF = 2'd1;
    localparam logic [1:0] CHOICE_VAL_ON  = 2'd2;

    // Characters
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LFHEX = 8'h66;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_F     = 8'h46;

    localparam int          KEY_RECORD_LEN = 45;
    localparam logic [5:0]  KEY_LEN        = 6'(KEY_RECORD_LEN);
    localparam logic [5:0]  LINE_MAX       = 6'd63;
    localparam logic [5:0]  ANSWER_LEN     = 6'd3;

    // Character classes worked out once, in the front end
    typedef struct packed {
        logic digit;
        logic hex;
        logic comma;
        logic cr;
        logic lf;
        logic star;
        logic bang;
        logic t;
        logic f;
    } char_class_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  cmd_class;
        char_class_t cc;
    } item_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r.digit = (c >= CH_ZERO) && (c <= CH_NINE);
        r.hex   = r.digit || ((c >= CH_UA) && (c <= CH_UF))
                  || ((c >= CH_LA) && (c <= CH_LFHEX));
        r.comma = (c == CH_COMMA);
        r.cr    = (c == CH_CR);
        r.lf    = (c == CH_LF);
        r.star  = (c == CH_STAR);
        r.bang  = (c == CH_BANG);
        r.t     = (c == CH_T);
        r.f     = (c == CH_F);
        return r;
    endfunction

    // Whether a character fits the key record format at a given position.
    function automatic logic key_char_ok(input logic [5:0] pos, input char_class_t cc);
        logic ok;
        if (pos >= KEY_LEN)
            ok = 1'b0;
        else if (pos == 6'd2 || pos == 6'd6 || pos == 6'd10)
            ok = cc.comma;
        else if (pos < 6'd10)
            ok = cc.digit;
        else if (pos < KEY_LEN - 6'd2)
            ok = cc.hex;
        else if (pos == KEY_LEN - 6'd2)
            ok = cc.cr;
        else
            ok = cc.lf;
        return ok;
    endfunction

endpackage

// ===== rtl/vrst_if.sv =====
// ----------------------------------------------------------------------------
// vrst interfaces
// Request and response channels of the session tracker, valid/ready.
// ----------------------------------------------------------------------------
interface vrst_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] cmd_class;
    logic [7:0] rx_byte;

    modport source (output valid, kind, cmd_class, rx_byte, input ready);
    modport sink   (input valid, kind, cmd_class, rx_byte, output ready);
endinterface

interface vrst_rsp_if #(
    parameter int PENDING_DEPTH = 8
);
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic             line_done;
    logic [1:0]       response_kind;
    logic             validation_on;
    logic             recording_on;
    logic             send_allowed;
    logic [31:0]      seq_count;
    logic [CNT_W-1:0] pending_count;

    modport source (output valid, status, line_done, response_kind, validation_on,
                    recording_on, send_allowed, seq_count, pending_count,
                    input ready);
    modport sink   (input valid, status, line_done, response_kind, validation_on,
                    recording_on, send_allowed, seq_count, pending_count,
                    output ready);
endinterface

// ===== rtl/vrst_front.sv =====
// ----------------------------------------------------------------------------
// vrst_front
// Accepts request beats, classifies the received character and holds the
// classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module vrst_front (
    input  logic            clk,
    input  logic            rst_n,
    vrst_req_if.sink        req,
    output logic            q_valid,
    output vrst_pkg::item_t q_item,
    input  logic            q_pop
);

    vrst_pkg::item_t entry_reg [2];
    vrst_pkg::item_t new_item;
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;

    assign req.ready = (count_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.kind      = req.kind;
        new_item.cmd_class = req.cmd_class;
        new_item.cc        = vrst_pkg::classify(req.rx_byte);
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
            count_next = count_reg + 2'd1;
        else if (!push && q_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= new_item;
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("front queue popped while empty");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("front queue count did not follow a lone push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> wr_ptr_reg != rd_ptr_reg)
        else $error("front queue pointers disagree with count");

endmodule

// ===== rtl/vrst_back.sv =====
// ----------------------------------------------------------------------------
// vrst_back
// Holds the session state, carries out one classified item per cycle when not
// stalled and keeps the pending flag-command queue and the registered response.
// ----------------------------------------------------------------------------
module vrst_back #(
    parameter int PENDING_DEPTH = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  vrst_pkg::item_t q_item,
    output logic            q_pop,
    vrst_rsp_if.source      rsp
);

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int PTR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int SUM_W = CNT_W + 1;

    // Session state
    logic             init_reg, init_next;
    logic             qval_sent_reg, qval_sent_next;
    logic             val_reg, val_next;
    logic             rec_reg, rec_next;
    logic [1:0]       choice_reg, choice_next;
    logic             fap_reg, fap_next;
    logic             sap_reg, sap_next;
    logic [31:0]      seq_reg, seq_next;

    // Pending queue
    logic [2:0]       pend_mem [PENDING_DEPTH];
    logic [2:0]       head_cls_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail;
    logic             push;
    logic [2:0]       push_cls;
    logic             pop;
    logic             full;

    // Line framing
    logic [5:0]       len_reg, len_next;
    logic             fc_star_reg, fc_star_next;
    logic             fc_bang_reg, fc_bang_next;
    logic             fc_t_reg, fc_t_next;
    logic             fc_f_reg, fc_f_next;
    logic             last_cr_reg, last_cr_next;
    logic             key_ok_reg, key_ok_next;

    // Response register
    logic             out_valid_reg;
    logic [2:0]       status_reg, status_next;
    logic             done_reg, done_next;
    logic [1:0]       rkind_reg, rkind_next;

    logic             fire;
    logic             send_ok;
    logic             flag_cmd;
    logic [1:0]       seq_inc;
    logic [5:0]       len_inc;
    logic             first_star, first_bang, first_t, first_f;
    logic             key_ok_now;
    logic             is_key;

    assign fire    = q_valid && (!out_valid_reg || rsp.ready);
    assign q_pop   = fire;
    assign send_ok = !(val_reg && rec_reg);
    assign full    = (cnt_reg == CNT_W'(PENDING_DEPTH));
    assign flag_cmd = (q_item.cmd_class >= vrst_pkg::CLS_REC_TRUE)
                      && (q_item.cmd_class <= vrst_pkg::CLS_VALOFF);

    // Slot after the last queued entry, wrapped by one compare and subtract.
    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(cnt_reg);
        if (tail_sum >= SUM_W'(PENDING_DEPTH))
            tail_sum = tail_sum - SUM_W'(PENDING_DEPTH);
        tail = tail_sum[PTR_W-1:0];
    end

    always_comb
    begin
        len_inc    = (len_reg < vrst_pkg::LINE_MAX) ? len_reg + 6'd1 : len_reg;
        first_star = (len_reg == 6'd0) ? q_item.cc.star : fc_star_reg;
        first_bang = (len_reg == 6'd0) ? q_item.cc.bang : fc_bang_reg;
        first_t    = (len_reg == 6'd0) ? q_item.cc.t    : fc_t_reg;
        first_f    = (len_reg == 6'd0) ? q_item.cc.f    : fc_f_reg;
        key_ok_now = key_ok_reg && vrst_pkg::key_char_ok(len_reg, q_item.cc);
        is_key     = key_ok_now && (len_inc == vrst_pkg::KEY_LEN);
    end

    always_comb
    begin
        init_next      = init_reg;
        qval_sent_next = qval_sent_reg;
        val_next       = val_reg;
        rec_next       = rec_reg;
        choice_next    = choice_reg;
        fap_next       = fap_reg;
        sap_next       = sap_reg;
        len_next       = len_reg;
        fc_star_next   = fc_star_reg;
        fc_bang_next   = fc_bang_reg;
        fc_t_next      = fc_t_reg;
        fc_f_next      = fc_f_reg;
        last_cr_next   = last_cr_reg;
        key_ok_next    = key_ok_reg;
        status_next    = vrst_pkg::ST_OK;
        done_next      = 1'b0;
        rkind_next     = vrst_pkg::RK_NONE;
        seq_inc        = 2'd0;
        push           = 1'b0;
        push_cls       = vrst_pkg::CLS_OTHER;
        pop            = 1'b0;

        if (fire)
        begin
            unique case (q_item.kind)
                vrst_pkg::KIND_SEND:
                begin
                    if (!init_reg)
                        status_next = vrst_pkg::ST_NOT_OK;
                    else if (!flag_cmd && !send_ok)
                        status_next = vrst_pkg::ST_NOT_OK;
                    else if (q_item.cmd_class >= vrst_pkg::CLS_UNKNOWN)
                        status_next = vrst_pkg::ST_UNKNOWN;
                    else
                    begin
                        seq_inc = 2'd1;
                        if (flag_cmd)
                        begin
                            if (full)
                                status_next = vrst_pkg::ST_QUEUE_FULL;
                            else
                            begin
                                push     = 1'b1;
                                push_cls = q_item.cmd_class;
                            end
                        end
                    end
                end
                vrst_pkg::KIND_INIT:
                begin
                    init_next = 1'b1;
                    if (!qval_sent_reg)
                    begin
                        if (!send_ok)
                            status_next = vrst_pkg::ST_NOT_OK;
                        else
                        begin
                            seq_inc        = 2'd1;
                            qval_sent_next = 1'b1;
                        end
                    end
                    // RECORD FALSE follows once validation is known to be on.
                    if (status_next == vrst_pkg::ST_OK
                        && choice_reg == vrst_pkg::CHOICE_VAL_ON)
                    begin
                        seq_inc = seq_inc + 2'd1;
                        if (full)
                            status_next = vrst_pkg::ST_QUEUE_FULL;
                        else
                        begin
                            push     = 1'b1;
                            push_cls = vrst_pkg::CLS_REC_FALSE;
                        end
                    end
                    if (status_next == vrst_pkg::ST_OK
                        && choice_reg == vrst_pkg::CHOICE_UNKNOWN)
                        status_next = vrst_pkg::ST_INIT_INCMP;
                end
                vrst_pkg::KIND_BYTE:
                begin
                    if (last_cr_reg && q_item.cc.lf)
                    begin
                        done_next = 1'b1;
                        if (send_ok || cnt_reg != '0)
                            rkind_next = (!send_ok && is_key) ? vrst_pkg::RK_OTHER
                                                              : vrst_pkg::RK_DEVICE;
                        else
                            rkind_next = vrst_pkg::RK_OTHER;

                        if (rkind_next == vrst_pkg::RK_DEVICE)
                        begin
                            if (cnt_reg != '0)
                            begin
                                if (first_star)
                                begin
                                    pop = 1'b1;
                                    case (head_cls_reg)
                                        vrst_pkg::CLS_REC_TRUE:   rec_next = 1'b1;
                                        vrst_pkg::CLS_REC_FALSE:  rec_next = 1'b0;
                                        vrst_pkg::CLS_VALIDATION: val_next = 1'b1;
                                        vrst_pkg::CLS_VALOFF:
                                        begin
                                            val_next = 1'b0;
                                            rec_next = 1'b0;
                                        end
                                        default: ;
                                    endcase
                                end
                                else if (first_bang)
                                    pop = 1'b1;
                            end

                            if (fap_reg)
                            begin
                                fap_next = 1'b0;
                                if (len_inc != vrst_pkg::ANSWER_LEN)
                                    status_next = vrst_pkg::ST_QVAL_BAD;
                                else if (first_t)
                                begin
                                    choice_next = vrst_pkg::CHOICE_VAL_ON;
                                    val_next    = 1'b1;
                                    sap_next    = 1'b1;
                                end
                                else if (first_f)
                                begin
                                    choice_next = vrst_pkg::CHOICE_VAL_OFF;
                                    val_next    = 1'b0;
                                    rec_next    = 1'b0;
                                    sap_next    = 1'b1;
                                end
                                else
                                    status_next = vrst_pkg::ST_QVAL_BAD;
                            end
                            else if (sap_reg && choice_reg == vrst_pkg::CHOICE_VAL_ON)
                            begin
                                sap_next = 1'b0;
                                if (len_inc != vrst_pkg::ANSWER_LEN || !first_star)
                                    status_next = vrst_pkg::ST_RECORD_BAD;
                                else
                                    rec_next = 1'b0;
                            end
                        end

                        len_next     = 6'd0;
                        fc_star_next = 1'b0;
                        fc_bang_next = 1'b0;
                        fc_t_next    = 1'b0;
                        fc_f_next    = 1'b0;
                        last_cr_next = 1'b0;
                        key_ok_next  = 1'b1;
                    end
                    else
                    begin
                        len_next     = len_inc;
                        fc_star_next = first_star;
                        fc_bang_next = first_bang;
                        fc_t_next    = first_t;
                        fc_f_next    = first_f;
                        key_ok_next  = key_ok_now;
                        last_cr_next = q_item.cc.cr;
                    end
                end
                default: ;
            endcase
        end

        seq_next  = seq_reg + 32'(seq_inc);
        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (push)
            cnt_next = cnt_reg + CNT_W'(1);
        if (pop)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            head_next = (head_reg == PTR_W'(PENDING_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= 1'b0;
            qval_sent_reg <= 1'b0;
            val_reg       <= 1'b0;
            rec_reg       <= 1'b0;
            choice_reg    <= vrst_pkg::CHOICE_UNKNOWN;
            fap_reg       <= 1'b1;
            sap_reg       <= 1'b0;
            seq_reg       <= '0;
            head_reg      <= '0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            fc_star_reg   <= 1'b0;
            fc_bang_reg   <= 1'b0;
            fc_t_reg      <= 1'b0;
            fc_f_reg      <= 1'b0;
            last_cr_reg   <= 1'b0;
            key_ok_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            init_reg      <= init_next;
            qval_sent_reg <= qval_sent_next;
            val_reg       <= val_next;
            rec_reg       <= rec_next;
            choice_reg    <= choice_next;
            fap_reg       <= fap_next;
            sap_reg       <= sap_next;
            seq_reg       <= seq_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            fc_star_reg   <= fc_star_next;
            fc_bang_reg   <= fc_bang_next;
            fc_t_reg      <= fc_t_next;
            fc_f_reg      <= fc_f_next;
            last_cr_reg   <= last_cr_next;
            key_ok_reg    <= key_ok_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            done_reg   <= done_next;
            rkind_reg  <= rkind_next;
        end
    end

    // The head entry is registered ahead; a push into the slot that is
    // about to become the head is forwarded past the memory.
    always_ff @(posedge clk)
    begin
        if (push)
            pend_mem[tail] <= push_cls;
        if (push && tail == head_next)
            head_cls_reg <= push_cls;
        else
            head_cls_reg <= pend_mem[head_next];
    end

    // Flags and counters are shown as they stand after the item, and only
    // change when an item is carried out, so they are read from state.
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.line_done     = done_reg;
    assign rsp.response_kind = rkind_reg;
    assign rsp.validation_on = val_reg;
    assign rsp.recording_on  = rec_reg;
    assign rsp.send_allowed  = !(val_reg && rec_reg);
    assign rsp.seq_count     = seq_reg;
    assign rsp.pending_count = cnt_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(PENDING_DEPTH))
        else $error("pending count beyond queue depth");

    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && pop) && (!pop || cnt_reg != '0) && (!push || !full))
        else $error("pending queue push or pop out of order");

    a_choice_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        (choice_reg != vrst_pkg::CHOICE_UNKNOWN || sap_reg) |-> !fap_reg)
        else $error("init answer state inconsistent");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> $stable(seq_reg) && $stable(cnt_reg))
        else $error("state moved while the response was stalled");

endmodule

// ===== rtl/validation_record_session_tracker.sv =====
// ----------------------------------------------------------------------------
// validation_record_session_tracker
// Tracks the command session with a serial instrument: send gating, init
// answers, CRLF line framing, key record checks and pending flag commands.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat carries
//  req      in         kind, cmd_class, rx_byte
//  rsp      out        status, line_done, response_kind, validation_on,
//                      recording_on, send_allowed, seq_count, pending_count
//
// One request beat is taken every cycle while req.ready is high; each gives
// exactly one response beat via the front queue, then the response register.
// The back end carries out one item per unstalled cycle, which sets the rate.
// Reset clears all session, framing and queue state; no clearing pass.
// A stalled response holds the back end; the two-entry front queue keeps
// req.ready high until both of its entries are full.
// ----------------------------------------------------------------------------
module validation_record_session_tracker #(
    parameter int PENDING_DEPTH = 8
) (
    input logic        clk,
    input logic        rst_n,
    vrst_req_if.sink   req,
    vrst_rsp_if.source rsp
);

    logic            q_valid;
    logic            q_pop;
    vrst_pkg::item_t q_item;

    vrst_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    vrst_back #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule
